[src/ftsa_pkg.sv]
// ----------------------------------------------------------------------------
// ftsa_pkg
// Shared types and constants of the file table sector allocator.
// ----------------------------------------------------------------------------
package ftsa_pkg;

    localparam int NodeCount      = 64;
    localparam int SectorCount    = 256;
    localparam int ListCount      = 32;
    localparam int SectorsPerFile = 16;
    localparam int NameBytes      = 14;
    localparam int ReservedSecs   = 32;

    localparam int NodeW   = $clog2(NodeCount);
    localparam int SecW    = $clog2(SectorCount);
    localparam int ListW   = $clog2(ListCount);
    localparam int SlotW   = $clog2(SectorsPerFile);
    localparam int LslotW  = ListW + SlotW;
    localparam int MaxSize = SectorsPerFile * 512;

    localparam logic [7:0] FolderMark = 8'hFF;
    localparam logic [7:0] RootParent = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NO_NODE  = 3'd2,
        ST_BAD_DIR  = 3'd3,
        ST_NO_SPACE = 3'd4,
        ST_NO_LIST  = 3'd5,
        ST_NOT_FND  = 3'd6,
        ST_IS_DIR   = 3'd7
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [63:0] name_low;
        logic [47:0] name_high;
        logic [7:0]  parent;
        logic [15:0] file_size;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_sector;
        logic [7:0]  sector;
        logic [3:0]  chunk;
        logic [13:0] size_found;
        logic        last;
    } t_rsp;

endpackage

[src/file_table_sector_allocator_unit.sv]
// ----------------------------------------------------------------------------
// file_table_sector_allocator_unit
// Node table, sector bitmap and sector lists with create and open requests.
// ----------------------------------------------------------------------------
// Usage: a request transfers on the input channel when i_valid is high and
// o_stall low. Results leave on the output channel, one per transfer, the
// final one with last set. One request is processed at a time; the next one
// is taken after the last result of the current one has transferred.
// Sequence: a sequencer walks the node memory (once to find the name, once
// for a free node), the sector bitmap and the list heads, one entry a cycle,
// through registered read ports. A folder create walks all three; a file
// create adds a list clear and a bitmap walk that takes the sectors and holds
// while a result waits in the output register. A rejected create ends after
// the walk that fails. An open walks the node memory, reads the node, counts
// its list slots and emits one result per slot, or a single one if none.
// Reset: the control logic clears at once; a clearing pass then writes all
// 64 nodes and 512 list slots, and writes the bitmap with the 32 reserved
// sectors marked used, during which no request is accepted.
// Stall: a result holds in the output register while i_stall is high; the
// sequencer waits on it.
// ----------------------------------------------------------------------------
module file_table_sector_allocator_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ftsa_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output ftsa_pkg::t_rsp  o_rsp
);

    localparam int NW = ftsa_pkg::NodeW;
    localparam int SW = ftsa_pkg::SecW;
    localparam int LW = ftsa_pkg::ListW;
    localparam int PW = ftsa_pkg::SlotW;
    localparam int QW = ftsa_pkg::LslotW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIND, S_FREE, S_PAR, S_CNT, S_LIST,
        S_WNODE, S_ALLOC, S_OREAD, S_EMIT, S_WAIT
    } t_state;

    // memories
    logic [111:0] m_name   [ftsa_pkg::NodeCount];
    logic [7:0]   m_parent [ftsa_pkg::NodeCount];
    logic [7:0]   m_lidx   [ftsa_pkg::NodeCount];
    logic         m_used   [ftsa_pkg::SectorCount];
    logic [7:0]   m_list   [ftsa_pkg::ListCount * ftsa_pkg::SectorsPerFile];

    t_state r_state;
    logic [9:0]   r_cnt;      // walk index, one beyond for the read latency
    logic [111:0] r_name;
    logic [7:0]   r_par;
    logic [15:0]  r_size;
    logic         r_kind;
    logic [NW-1:0] r_node;
    logic         r_found;
    logic [8:0]   r_avail;
    logic [4:0]   r_need;
    logic [LW-1:0] r_list;
    logic         r_lfound;
    logic [4:0]   r_j;
    logic [7:0]   r_li;
    logic [4:0]   r_ocount;
    logic         r_ovalid;
    ftsa_pkg::t_rsp r_rsp;
    logic         r_rd;       // a read was issued in the previous cycle

    // registered read ports
    logic [111:0] q_name;
    logic [7:0]   q_parent, q_lidx, q_list;
    logic         q_used;

    // memory port controls
    logic           n_nwe;  logic [NW-1:0] n_naddr; logic [111:0] n_nname;
    logic [7:0]     n_npar, n_nlidx;
    logic           n_uwe;  logic [SW-1:0] n_uaddr; logic n_uval;
    logic           n_lwe;  logic [QW-1:0] n_laddr; logic [7:0] n_lval;
    logic [NW-1:0]  a_node;
    logic [SW-1:0]  a_sec;
    logic [QW-1:0]  a_list;

    // name normalization: clear bytes from the first zero byte on
    logic [111:0] w_raw;
    logic [111:0] w_norm;
    logic         w_zero;
    assign w_raw = {i_req.name_high, i_req.name_low};
    always_comb begin
        w_norm = '0;
        w_zero = 1'b0;
        for (int b = 0; b < 14; b++) begin
            logic [7:0] byt;
            byt = w_raw[8*b +: 8];
            if (byt == 8'd0 || b >= ftsa_pkg::NameBytes) w_zero = 1'b1;
            if (!w_zero) w_norm[8*b +: 8] = byt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_nwe) begin
            m_name[n_naddr]   <= n_nname;
            m_parent[n_naddr] <= n_npar;
            m_lidx[n_naddr]   <= n_nlidx;
        end
        q_name   <= m_name[a_node];
        q_parent <= m_parent[a_node];
        q_lidx   <= m_lidx[a_node];
    end

    always_ff @(posedge i_clk) begin
        if (n_uwe) m_used[n_uaddr] <= n_uval;
        q_used <= m_used[a_sec];
    end

    always_ff @(posedge i_clk) begin
        if (n_lwe) m_list[n_laddr] <= n_lval;
        q_list <= m_list[a_list];
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    logic [4:0] w_need;
    assign w_need = 5'((r_size + 16'd511) >> 9);

    logic [NW-1:0] w_cidx;
    assign w_cidx = NW'(r_cnt - 10'd1);
    logic w_last_rd;

    // name and parent match on the entry read in the previous cycle
    logic w_hit;
    assign w_hit = (r_cnt != 10'd0) && (q_name == r_name) && (q_parent == r_par);

    function automatic ftsa_pkg::t_rsp err(input ftsa_pkg::t_status s);
        ftsa_pkg::t_rsp r;
        r = '0;
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    // address and write control
    always_comb begin
        a_node  = r_cnt[NW-1:0];
        a_sec   = r_cnt[SW-1:0];
        a_list  = {r_cnt[LW-1:0], PW'(0)};
        n_nwe   = 1'b0; n_naddr = r_node; n_nname = r_name;
        n_npar  = r_par; n_nlidx = 8'(r_list);
        n_uwe   = 1'b0; n_uaddr = r_cnt[SW-1:0]; n_uval = 1'b1;
        n_lwe   = 1'b0; n_laddr = r_cnt[QW-1:0]; n_lval = 8'd0;
        w_last_rd = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_nwe = (r_cnt < 10'(ftsa_pkg::NodeCount));
                n_naddr = r_cnt[NW-1:0]; n_nname = '0; n_npar = '0; n_nlidx = '0;
                n_uwe = (r_cnt < 10'(ftsa_pkg::SectorCount));
                n_uval = (r_cnt < 10'(ftsa_pkg::ReservedSecs));
                n_lwe = 1'b1;
            end
            S_PAR:   a_node = r_par[NW-1:0];
            S_WNODE: begin
                n_nwe = 1'b1;
                n_nlidx = (r_size == 16'd0) ? ftsa_pkg::FolderMark : 8'(r_list);
            end
            S_ALLOC: begin
                // pass over list slots clears, then sectors are taken
                if (r_cnt[9]) begin
                    n_lwe = 1'b1;
                    n_laddr = {r_list, r_cnt[PW-1:0]};
                end else if (r_rd && !q_used && r_j < r_need && !r_ovalid) begin
                    n_uwe = 1'b1; n_uaddr = SW'(r_cnt - 10'd1);
                    n_lwe = 1'b1; n_laddr = {r_list, r_j[PW-1:0]};
                    n_lval = 8'(r_cnt - 10'd1);
                end
            end
            S_OREAD: a_node = r_node;
            S_EMIT:  a_list = {r_li[LW-1:0], r_j[PW-1:0]};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_rd     <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_rd <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt == 10'(ftsa_pkg::ListCount * ftsa_pkg::SectorsPerFile - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_name  <= w_norm;
                    r_par   <= i_req.parent;
                    r_size  <= i_req.file_size;
                    r_kind  <= i_req.kind;
                    r_found <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    // reads issue at r_cnt, results compare in the cycle after
                    r_cnt <= r_cnt + 10'd1;
                    if (w_hit && !r_found) begin
                        r_found <= 1'b1;
                        r_node  <= w_cidx;
                    end
                    if (r_cnt == 10'(ftsa_pkg::NodeCount)) begin
                        r_cnt <= '0;
                        if (r_kind) begin
                            if (r_found || w_hit) r_state <= S_OREAD;
                            else begin
                                r_rsp <= err(ftsa_pkg::ST_NOT_FND);
                                r_ovalid <= 1'b1; r_state <= S_WAIT;
                            end
                        end else if (r_found || w_hit) begin
                            r_rsp <= err(ftsa_pkg::ST_EXISTS);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else r_state <= S_FREE;
                    end
                end
                S_FREE: begin
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt != 0 && !r_found && q_name[7:0] == 8'd0) begin
                        r_found <= 1'b1;
                        r_node  <= w_cidx;
                    end
                    if (r_cnt == 10'(ftsa_pkg::NodeCount)) begin
                        r_cnt <= '0;
                        if (!r_found && !(q_name[7:0] == 8'd0)) begin
                            r_rsp <= err(ftsa_pkg::ST_NO_NODE);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else begin
                            if (!r_found) begin
                                r_found <= 1'b1; r_node <= w_cidx;
                            end
                            r_state <= S_PAR;
                        end
                    end
                end
                S_PAR: begin
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt == 10'd1) begin
                        r_cnt <= '0; r_avail <= '0;
                        if (r_par != ftsa_pkg::RootParent &&
                            (r_par >= 8'(ftsa_pkg::NodeCount) ||
                             q_lidx != ftsa_pkg::FolderMark)) begin
                            r_rsp <= err(ftsa_pkg::ST_BAD_DIR);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt != 0 && !q_used) r_avail <= r_avail + 9'd1;
                    if (r_cnt == 10'(ftsa_pkg::SectorCount)) begin
                        r_cnt <= '0; r_lfound <= 1'b0;
                        r_need <= w_need;
                        if ((r_avail + 9'(!q_used)) < 9'(w_need) ||
                            r_size > 16'(ftsa_pkg::MaxSize)) begin
                            r_rsp <= err(ftsa_pkg::ST_NO_SPACE);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else r_state <= S_LIST;
                    end
                end
                S_LIST: begin
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt != 0 && !r_lfound && q_list == 8'd0) begin
                        r_lfound <= 1'b1; r_list <= LW'(r_cnt - 10'd1);
                    end
                    if (r_cnt == 10'(ftsa_pkg::ListCount)) begin
                        if (!r_lfound && q_list != 8'd0 && r_size != 16'd0) begin
                            r_rsp <= err(ftsa_pkg::ST_NO_LIST);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else begin
                            if (!r_lfound && q_list == 8'd0) begin
                                r_lfound <= 1'b1; r_list <= LW'(r_cnt - 10'd1);
                            end
                            r_state <= S_WNODE;
                        end
                    end
                end
                S_WNODE: begin
                    if (r_size == 16'd0) begin
                        r_rsp <= err(ftsa_pkg::ST_OK);
                        r_ovalid <= 1'b1; r_state <= S_WAIT;
                    end else begin
                        r_cnt <= 10'h200; r_j <= '0;
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (r_cnt[9]) begin
                        r_cnt <= r_cnt + 10'd1;
                        if (r_cnt[PW-1:0] == PW'(ftsa_pkg::SectorsPerFile - 1))
                            r_cnt <= '0;
                    end else if (!r_ovalid) begin
                        if (r_rd && !q_used && r_j < r_need) begin
                            r_rsp <= '{status: ftsa_pkg::ST_OK, has_sector: 1'b1,
                                       sector: 8'(r_cnt - 10'd1), chunk: r_j[3:0],
                                       size_found: '0, last: (r_j + 5'd1 == r_need)};
                            r_ovalid <= 1'b1;
                            r_j <= r_j + 5'd1;
                            if (r_j + 5'd1 == r_need) r_state <= S_WAIT;
                        end else begin
                            r_rd  <= 1'b1;
                            r_cnt <= r_cnt + 10'd1;
                        end
                    end
                end
                S_OREAD: begin
                    // node read issues first, its list index is checked in the next cycle
                    r_cnt <= r_cnt + 10'd1;
                    if (r_cnt == 10'd1) begin
                        r_li <= q_lidx;
                        r_j <= '0; r_ocount <= '0;
                        r_cnt <= '0;
                        if (q_lidx == ftsa_pkg::FolderMark) begin
                            r_rsp <= err(ftsa_pkg::ST_IS_DIR);
                            r_ovalid <= 1'b1; r_state <= S_WAIT;
                        end else r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // count entries up to first zero, each slot read and then checked
                    // r_cnt[0]: read pending; r_cnt[1] counting done
                    if (!r_cnt[1]) begin
                        if (r_li >= 8'(ftsa_pkg::ListCount)) begin
                            r_cnt <= 10'd2; r_j <= '0;
                        end else if (!r_cnt[0]) r_cnt <= 10'd1;
                        else begin
                            if (q_list == 8'd0 || r_j == 5'(ftsa_pkg::SectorsPerFile - 1)) begin
                                r_ocount <= r_j + 5'(q_list != 8'd0);
                                r_cnt <= 10'd2; r_j <= '0;
                            end else begin
                                r_j <= r_j + 5'd1; r_cnt <= 10'd0;
                            end
                        end
                    end else if (r_ocount == 5'd0) begin
                        r_rsp <= err(ftsa_pkg::ST_OK);
                        r_ovalid <= 1'b1; r_state <= S_WAIT;
                    end else if (!r_ovalid || !i_stall) begin
                        if (!r_cnt[0]) r_cnt <= 10'd3;
                        else begin
                            r_rsp <= '{status: ftsa_pkg::ST_OK, has_sector: 1'b1,
                                       sector: q_list, chunk: r_j[3:0],
                                       size_found: 14'({r_ocount, 9'd0}),
                                       last: (r_j + 5'd1 == r_ocount)};
                            r_ovalid <= 1'b1;
                            r_j <= r_j + 5'd1;
                            r_cnt <= 10'd2;
                            if (r_j + 5'd1 == r_ocount) r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= r_ovalid && i_stall;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[dv/tb_file_table_sector_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_file_table_sector_allocator_unit
// Drives create and open requests with random gaps and output stalls, predicts
// every result from a local model of node table, bitmap and sector lists, and
// compares each whole result against the prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_file_table_sector_allocator_unit;

    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_OPEN   = 1'b1;
    localparam int   DIRECTED_N  = 22;
    localparam int   RANDOM_N    = 188;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    ftsa_pkg::t_req   i_req;
    logic             o_valid;
    logic             i_stall;
    ftsa_pkg::t_rsp   o_rsp;

    file_table_sector_allocator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // model of the block state
    logic        used_map [ftsa_pkg::SectorCount];
    logic [63:0] tbl_name_lo [ftsa_pkg::NodeCount];
    logic [47:0] tbl_name_hi [ftsa_pkg::NodeCount];
    logic [7:0]  tbl_parent [ftsa_pkg::NodeCount];
    logic [7:0]  tbl_list [ftsa_pkg::NodeCount];
    logic [7:0]  list_slots [ftsa_pkg::ListCount*ftsa_pkg::SectorsPerFile];

    ftsa_pkg::t_rsp pending_rsp[$];
    int          errors;
    int          rsp_count;
    int          sector_rsp_count;
    int          req_count;

    // directed rows: request plus a typed-in status where obvious
    ftsa_pkg::t_req    dir_req [DIRECTED_N];
    logic              dir_has_exp [DIRECTED_N];
    ftsa_pkg::t_status dir_exp [DIRECTED_N];

    // names of created nodes, reused for opens and duplicates
    logic [63:0] known_lo[$];
    logic [47:0] known_hi[$];
    logic [7:0]  known_par[$];
    logic [7:0]  folder_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end

    function automatic ftsa_pkg::t_rsp make_rsp(ftsa_pkg::t_status st, logic has,
                                                logic [7:0] sec, logic [3:0] chk,
                                                logic [13:0] sz, logic lst);
        ftsa_pkg::t_rsp r;
        r.status = st;
        r.has_sector = has;
        r.sector = sec;
        r.chunk = chk;
        r.size_found = sz;
        r.last = lst;
        return r;
    endfunction

    task automatic model_reset();
        for (int i = 0; i < ftsa_pkg::SectorCount; i++)
            used_map[i] = (i < ftsa_pkg::ReservedSecs);
        for (int i = 0; i < ftsa_pkg::NodeCount; i++) begin
            tbl_name_lo[i] = '0;
            tbl_name_hi[i] = '0;
            tbl_parent[i] = '0;
            tbl_list[i] = '0;
        end
        for (int i = 0; i < ftsa_pkg::ListCount*ftsa_pkg::SectorsPerFile; i++)
            list_slots[i] = '0;
    endtask

    function automatic int find_entry(logic [63:0] lo, logic [47:0] hi, logic [7:0] par);
        for (int i = 0; i < ftsa_pkg::NodeCount; i++)
            if (tbl_name_lo[i] == lo && tbl_name_hi[i] == hi && tbl_parent[i] == par)
                return i;
        return -1;
    endfunction

    // compute the results of one request and update the model state
    task automatic predict_request(ftsa_pkg::t_req rq);
        logic [63:0] lo;
        logic [47:0] hi;
        logic [7:0]  b;
        bit          ended;
        int          node, lst, avail, needed, j, li, cnt, spf;
        lo = '0;
        hi = '0;
        ended = 0;
        node = -1;
        lst = -1;
        avail = 0;
        cnt = 0;
        spf = ftsa_pkg::SectorsPerFile;
        // names compare as zero-ended strings
        for (int i = 0; i < ftsa_pkg::NameBytes; i++) begin
            b = (i < 8) ? rq.name_low[8*i +: 8] : rq.name_high[8*(i-8) +: 8];
            if (b == 8'd0) ended = 1;
            if (!ended) begin
                if (i < 8) lo[8*i +: 8] = b;
                else hi[8*(i-8) +: 8] = b;
            end
        end
        if (rq.kind == KIND_CREATE) begin
            if (find_entry(lo, hi, rq.parent) >= 0) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_EXISTS, 0, 0, 0, 0, 1));
                return;
            end
            for (int i = 0; i < ftsa_pkg::NodeCount; i++)
                if (node < 0 && tbl_name_lo[i][7:0] == 8'd0) node = i;
            if (node < 0) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_NO_NODE, 0, 0, 0, 0, 1));
                return;
            end
            if (rq.parent != ftsa_pkg::RootParent &&
                (rq.parent >= ftsa_pkg::NodeCount ||
                 tbl_list[rq.parent] != ftsa_pkg::FolderMark)) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_BAD_DIR, 0, 0, 0, 0, 1));
                return;
            end
            needed = (int'(rq.file_size) + 511) / 512;
            for (int i = 0; i < ftsa_pkg::SectorCount; i++) if (!used_map[i]) avail++;
            if (avail < needed || rq.file_size > ftsa_pkg::MaxSize) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_NO_SPACE, 0, 0, 0, 0, 1));
                return;
            end
            for (int i = 0; i < ftsa_pkg::ListCount; i++)
                if (lst < 0 && list_slots[i*spf] == 8'd0) lst = i;
            if (lst < 0 && rq.file_size > 0) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_NO_LIST, 0, 0, 0, 0, 1));
                return;
            end
            tbl_name_lo[node] = lo;
            tbl_name_hi[node] = hi;
            tbl_parent[node] = rq.parent;
            known_lo.push_back(rq.name_low);
            known_hi.push_back(rq.name_high);
            known_par.push_back(rq.parent);
            if (rq.file_size == 0) begin
                tbl_list[node] = ftsa_pkg::FolderMark;
                folder_ids.push_back(8'(node));
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_OK, 0, 0, 0, 0, 1));
                return;
            end
            tbl_list[node] = 8'(lst);
            for (int k = 0; k < spf; k++) list_slots[lst*spf+k] = '0;
            j = 0;
            for (int i = 0; i < ftsa_pkg::SectorCount && j < needed; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    list_slots[lst*spf+j] = 8'(i);
                    pending_rsp.push_back(make_rsp(ftsa_pkg::ST_OK, 1, 8'(i), 4'(j), 0,
                                                   j + 1 == needed));
                    j++;
                end
            end
        end else begin
            node = find_entry(lo, hi, rq.parent);
            if (node < 0) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_NOT_FND, 0, 0, 0, 0, 1));
                return;
            end
            li = tbl_list[node];
            if (li == ftsa_pkg::FolderMark) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_IS_DIR, 0, 0, 0, 0, 1));
                return;
            end
            if (li < ftsa_pkg::ListCount)
                while (cnt < spf && list_slots[li*spf+cnt] != 0)
                    cnt++;
            if (cnt == 0) begin
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_OK, 0, 0, 0, 0, 1));
                return;
            end
            for (int k = 0; k < cnt; k++)
                pending_rsp.push_back(make_rsp(ftsa_pkg::ST_OK, 1, list_slots[li*spf+k],
                                               4'(k), 14'(cnt*512), k + 1 == cnt));
        end
    endtask

    function automatic ftsa_pkg::t_req make_req(logic kd, logic [63:0] lo, logic [47:0] hi,
                                                logic [7:0] par, logic [15:0] sz);
        ftsa_pkg::t_req r;
        r.kind = kd;
        r.name_low = lo;
        r.name_high = hi;
        r.parent = par;
        r.file_size = sz;
        return r;
    endfunction

    // short printable name, sometimes with garbage after a zero byte
    function automatic ftsa_pkg::t_req random_name(ftsa_pkg::t_req r);
        int n;
        n = $urandom_range(1, 5);
        r.name_low = '0;
        r.name_high = '0;
        for (int i = 0; i < n; i++) r.name_low[8*i +: 8] = 8'($urandom_range(97, 100));
        if ($urandom_range(0, 5) == 0) r.name_high = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic ftsa_pkg::t_req random_req();
        ftsa_pkg::t_req r;
        int   sel;
        int   k;
        r = make_req(KIND_CREATE, 0, 0, ftsa_pkg::RootParent, 0);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            r = random_name(r);
            if (folder_ids.size() > 0 && $urandom_range(0, 1))
                r.parent = folder_ids[$urandom_range(0, folder_ids.size()-1)];
            r.file_size = ($urandom_range(0, 4) == 0) ? 16'd0
                        : 16'($urandom_range(1, $urandom_range(0, 3) == 0 ?
                                             ftsa_pkg::MaxSize : 1600));
        end else if (sel < 75 && known_lo.size() > 0) begin
            k = $urandom_range(0, known_lo.size()-1);
            r.kind = ($urandom_range(0, 3) == 0) ? KIND_CREATE : KIND_OPEN;
            r.name_low = known_lo[k];
            r.name_high = known_hi[k];
            r.parent = known_par[k];
            r.file_size = 16'($urandom_range(0, 2000));
        end else if (sel < 85) begin
            r = random_name(r);
            r.kind = KIND_OPEN;
        end else begin
            // noise over the full field ranges
            r.kind = 1'($urandom);
            r.name_low = {$urandom, $urandom};
            r.name_high = 48'({$urandom, $urandom});
            r.parent = 8'($urandom);
            r.file_size = 16'($urandom);
        end
        return r;
    endfunction

    // called at a falling edge; valid stays high into the next request when
    // the drawn gap is zero
    task automatic send_request(ftsa_pkg::t_req rq);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= rq;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(rq);
        req_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver: random stall and result check
    initial begin
        int gap;
        ftsa_pkg::t_rsp want;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            rsp_count++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %p", $time, o_rsp);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.has_sector) sector_rsp_count++;
                if (o_rsp !== want)
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_rsp);
                if (o_rsp !== want) errors++;
            end
        end
    end

    initial begin
        ftsa_pkg::t_rsp    want;
        ftsa_pkg::t_status got;
        logic [63:0] junk_lo;
        errors = 0;
        rsp_count = 0;
        sector_rsp_count = 0;
        req_count = 0;
        i_valid = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        model_reset();
        junk_lo = 64'h0000_0000_0000_4142;

        dir_req[0]  = make_req(KIND_OPEN,   64'h61, 0, ftsa_pkg::RootParent, 0);
        dir_req[1]  = make_req(KIND_CREATE, 64'h646972, 0, ftsa_pkg::RootParent, 0);
        dir_req[2]  = make_req(KIND_CREATE, 64'h66, 0, ftsa_pkg::RootParent, 16'd1);
        dir_req[3]  = make_req(KIND_CREATE, 64'h67, 0, 8'd0, 16'(ftsa_pkg::MaxSize));
        dir_req[4]  = make_req(KIND_CREATE, 64'h68, 0, ftsa_pkg::RootParent, 16'hFFFF);
        dir_req[5]  = make_req(KIND_CREATE, 64'h68, 0, ftsa_pkg::RootParent,
                               16'(ftsa_pkg::MaxSize + 1));
        dir_req[6]  = make_req(KIND_CREATE, 64'h69, 0, 8'd64, 16'd100);
        dir_req[7]  = make_req(KIND_CREATE, 64'h69, 0, 8'd254, 16'd100);
        dir_req[8]  = make_req(KIND_CREATE, 64'h69, 0, 8'd1, 16'd100);
        dir_req[9]  = make_req(KIND_CREATE, 64'h69, 0, 8'd5, 16'd100);
        dir_req[10] = make_req(KIND_CREATE, 64'h66, 48'hFFFF_FFFF_FFFF,
                               ftsa_pkg::RootParent, 16'd5);
        dir_req[11] = make_req(KIND_OPEN,   64'h66, 0, ftsa_pkg::RootParent, 0);
        dir_req[12] = make_req(KIND_OPEN,   64'h67, 0, 8'd0, 0);
        dir_req[13] = make_req(KIND_OPEN,   64'h646972, 0, ftsa_pkg::RootParent, 0);
        dir_req[14] = make_req(KIND_OPEN,   0, 0, 8'd0, 0);
        dir_req[15] = make_req(KIND_CREATE, 0, 0, ftsa_pkg::RootParent, 16'd0);
        dir_req[16] = make_req(KIND_CREATE, 64'hFFFF_FFFF_FFFF_FFFF,
                               48'hFFFF_FFFF_FFFF, 8'd0, 16'd513);
        dir_req[17] = make_req(KIND_OPEN,   64'hFFFF_FFFF_FFFF_FFFF,
                               48'h0000_0000_00FF, 8'd0, 0);
        dir_req[18] = make_req(KIND_CREATE, {56'hABCDEF, 8'h00}, 0,
                               ftsa_pkg::RootParent, 16'd512);
        dir_req[19] = make_req(KIND_CREATE, junk_lo, 0, ftsa_pkg::RootParent, 16'd1024);
        dir_req[20] = make_req(KIND_OPEN,   junk_lo | 64'hFF00_0000_0000_0000,
                               0, ftsa_pkg::RootParent, 0);
        dir_req[21] = make_req(KIND_CREATE, 64'h6A, 0, ftsa_pkg::RootParent, 16'd7000);
        for (int i = 0; i < DIRECTED_N; i++) dir_has_exp[i] = 1'b0;
        dir_has_exp[0] = 1'b1;  dir_exp[0] = ftsa_pkg::ST_NOT_FND;
        dir_has_exp[1] = 1'b1;  dir_exp[1] = ftsa_pkg::ST_OK;
        dir_has_exp[4] = 1'b1;  dir_exp[4] = ftsa_pkg::ST_NO_SPACE;
        dir_has_exp[5] = 1'b1;  dir_exp[5] = ftsa_pkg::ST_NO_SPACE;
        dir_has_exp[6] = 1'b1;  dir_exp[6] = ftsa_pkg::ST_BAD_DIR;
        dir_has_exp[7] = 1'b1;  dir_exp[7] = ftsa_pkg::ST_BAD_DIR;
        dir_has_exp[9] = 1'b1;  dir_exp[9] = ftsa_pkg::ST_BAD_DIR;
        dir_has_exp[10] = 1'b1; dir_exp[10] = ftsa_pkg::ST_EXISTS;
        dir_has_exp[13] = 1'b1; dir_exp[13] = ftsa_pkg::ST_IS_DIR;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_request(dir_req[i]);
            if (dir_has_exp[i]) begin
                want = pending_rsp[pending_rsp.size()-1];
                if (want.status != dir_exp[i]) begin
                    got = ftsa_pkg::t_status'(want.status);
                    $display("%0t: row %0d expected status %s, predictor gives %s", $time,
                             i, dir_exp[i].name(), got.name());
                    errors++;
                end
            end
        end
        // random traffic
        for (int i = 0; i < RANDOM_N; i++) send_request(random_req());
        i_valid <= 1'b0;
        fork
            wait_drained();
            begin
                repeat (2_000_000) @(posedge i_clk);
                $display("Drain timeout at %0t", $time);
            end
        join_any
        disable fork;
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_rsp.size());
            errors++;
        end
        $display("Covered %0d requests, %0d results (%0d with sectors), %0d failures",
                 req_count, rsp_count, sector_rsp_count, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
